FILE: design/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants for the mixed-radix index converter.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int NUM_POS   = 8;
    localparam int POS_W     = 3;
    localparam int DIGIT_W   = 4;
    localparam int COUNT_W   = 4;
    localparam int OUT_IDX_W = 32;

    typedef enum logic
    {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } mrc_cmd_t;

    typedef enum logic
    {
        OP_MAC = 1'b0,
        OP_DIV = 1'b1
    } mrc_op_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_ENC,
        S_DIV,
        S_DONE
    } mrc_state_t;

    typedef struct packed
    {
        mrc_op_t              op;
        logic [DIGIT_W-1:0]   radix;
        logic [DIGIT_W-1:0]   digit;
    } mrc_step_ctl_t;

endpackage

FILE: design/mrc_step_unit.sv
// ----------------------------------------------------------------------------
// mrc_step_unit
// Shared arithmetic step: one multiply-add of the accumulator by a radix, or
// one restoring-division bit step of the accumulator by a radix.
// ----------------------------------------------------------------------------
module mrc_step_unit
    import mrc_pkg::*;
#(
    parameter int INDEX_WIDTH = 32
)
(
    input  mrc_step_ctl_t            ctl,
    input  logic [INDEX_WIDTH-1:0]   acc,
    input  logic [DIGIT_W-1:0]       rem,
    output logic [INDEX_WIDTH-1:0]   acc_next,
    output logic [DIGIT_W-1:0]       rem_next
);

    logic [INDEX_WIDTH-1:0] prod;
    logic [DIGIT_W:0]       rem_shift;
    logic [DIGIT_W-1:0]     rem_diff;
    logic                   fits;

    always_comb
    begin
        prod      = acc * INDEX_WIDTH'(ctl.radix);
        rem_shift = {rem, acc[INDEX_WIDTH-1]};
        rem_diff  = rem_shift[DIGIT_W-1:0] - ctl.radix;
        fits      = (rem_shift >= {1'b0, ctl.radix});
        unique case (ctl.op)
            OP_MAC:
            begin
                acc_next = prod + INDEX_WIDTH'(ctl.digit);
                rem_next = '0;
            end
            OP_DIV:
            begin
                acc_next = {acc[INDEX_WIDTH-2:0], fits};
                rem_next = fits ? rem_diff : rem_shift[DIGIT_W-1:0];
            end
            default:
            begin
                acc_next = acc;
                rem_next = rem;
            end
        endcase
    end

endmodule

FILE: design/mixed_radix_index_convert_core.sv
// ----------------------------------------------------------------------------
// mixed_radix_index_convert_core
// Converts a vector of mixed-radix digits into an index and back.
// ----------------------------------------------------------------------------
// One request at a time; in_stall is high from acceptance until the result has
// moved into the output register, and the next request can be taken in the
// cycle after that. Encode runs one multiply-add per active digit; decode runs
// a one-bit restoring divider once per active digit. A result waiting at the
// output holds the core only once the next result is finished. The active
// count is sampled from the radix registers when a request is accepted.
module mixed_radix_index_convert_core
    import mrc_pkg::*;
#(
    parameter int MAX_DIGITS  = 8,
    parameter int INDEX_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [POS_W-1:0]     cfg_index,
    input  logic [DIGIT_W-1:0]   cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [31:0]          index_in,
    input  logic [DIGIT_W-1:0]   digit_in_0,
    input  logic [DIGIT_W-1:0]   digit_in_1,
    input  logic [DIGIT_W-1:0]   digit_in_2,
    input  logic [DIGIT_W-1:0]   digit_in_3,
    input  logic [DIGIT_W-1:0]   digit_in_4,
    input  logic [DIGIT_W-1:0]   digit_in_5,
    input  logic [DIGIT_W-1:0]   digit_in_6,
    input  logic [DIGIT_W-1:0]   digit_in_7,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [31:0]          index_out,
    output logic [COUNT_W-1:0]   active_count,
    output logic [DIGIT_W-1:0]   digit_out_0,
    output logic [DIGIT_W-1:0]   digit_out_1,
    output logic [DIGIT_W-1:0]   digit_out_2,
    output logic [DIGIT_W-1:0]   digit_out_3,
    output logic [DIGIT_W-1:0]   digit_out_4,
    output logic [DIGIT_W-1:0]   digit_out_5,
    output logic [DIGIT_W-1:0]   digit_out_6,
    output logic [DIGIT_W-1:0]   digit_out_7
);

    localparam int BIT_W = $clog2(INDEX_WIDTH);

    mrc_state_t               state_reg, state_next;
    logic [DIGIT_W-1:0]       radix_reg [NUM_POS];
    logic [DIGIT_W-1:0]       digit_in_reg [NUM_POS];
    logic [DIGIT_W-1:0]       digit_out_reg [NUM_POS];
    logic [DIGIT_W-1:0]       digit_out_next [NUM_POS];
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic [INDEX_WIDTH-1:0]   acc_reg, acc_next;
    logic [DIGIT_W-1:0]       rem_reg, rem_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    mrc_cmd_t                 cmd_reg, cmd_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0]     index_res_reg;
    logic [COUNT_W-1:0]       count_res_reg;
    logic [DIGIT_W-1:0]       digit_res_reg [NUM_POS];

    logic [COUNT_W-1:0]       active_now;
    logic                     accept;
    logic                     load;
    logic                     last_pos;
    logic                     last_bit;
    logic [COUNT_W-1:0]       last_idx;
    mrc_step_ctl_t            step_ctl;
    logic [INDEX_WIDTH-1:0]   unit_acc;
    logic [DIGIT_W-1:0]       unit_rem;

    mrc_step_unit #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_step (
        .ctl      (step_ctl),
        .acc      (acc_reg),
        .rem      (rem_reg),
        .acc_next (unit_acc),
        .rem_next (unit_rem)
    );

    always_comb
    begin
        logic run;
        run        = 1'b1;
        active_now = '0;
        for (int i = 0; i < NUM_POS; i++)
        begin
            if (run && (i < MAX_DIGITS) && (radix_reg[i] != '0))
            begin
                active_now = COUNT_W'(i + 1);
            end
            else
            begin
                run = 1'b0;
            end
        end
    end

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign load      = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign last_idx  = count_reg - COUNT_W'(1);
    assign last_pos  = ({1'b0, pos_reg} == last_idx);
    assign last_bit  = (bit_reg == BIT_W'(INDEX_WIDTH - 1));

    assign step_ctl.op    = (state_reg == S_DIV) ? OP_DIV : OP_MAC;
    assign step_ctl.radix = radix_reg[pos_reg];
    assign step_ctl.digit = digit_in_reg[pos_reg];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (active_now == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (cmd == CMD_DECODE)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_ENC;
                    end
                end
            end
            S_ENC:
            begin
                if (last_pos)
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (last_bit && (pos_reg == '0))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        bit_next       = bit_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        digit_out_next = digit_out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    count_next = active_now;
                    cmd_next   = mrc_cmd_t'(cmd);
                    bit_next   = '0;
                    rem_next   = '0;
                    for (int i = 0; i < NUM_POS; i++)
                    begin
                        digit_out_next[i] = '0;
                    end
                    if (cmd == CMD_DECODE)
                    begin
                        acc_next = INDEX_WIDTH'(index_in);
                        pos_next = POS_W'(active_now - COUNT_W'(1));
                    end
                    else
                    begin
                        acc_next = '0;
                        pos_next = '0;
                    end
                end
            end
            S_ENC:
            begin
                acc_next = unit_acc;
                if (!last_pos)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            S_DIV:
            begin
                acc_next = unit_acc;
                if (last_bit)
                begin
                    digit_out_next[pos_reg] = unit_rem;
                    rem_next                = '0;
                    bit_next                = '0;
                    pos_next                = pos_reg - POS_W'(1);
                end
                else
                begin
                    rem_next = unit_rem;
                    bit_next = bit_reg + BIT_W'(1);
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_POS; i++)
            begin
                radix_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                radix_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        bit_reg       <= bit_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        count_reg     <= count_next;
        cmd_reg       <= cmd_next;
        digit_out_reg <= digit_out_next;
        if (accept)
        begin
            digit_in_reg[0] <= digit_in_0;
            digit_in_reg[1] <= digit_in_1;
            digit_in_reg[2] <= digit_in_2;
            digit_in_reg[3] <= digit_in_3;
            digit_in_reg[4] <= digit_in_4;
            digit_in_reg[5] <= digit_in_5;
            digit_in_reg[6] <= digit_in_6;
            digit_in_reg[7] <= digit_in_7;
        end
        if (load)
        begin
            index_res_reg <= (cmd_reg == CMD_DECODE) ? '0 : OUT_IDX_W'(acc_reg);
            count_res_reg <= count_reg;
            digit_res_reg <= digit_out_reg;
        end
    end

    assign index_out    = index_res_reg;
    assign active_count = count_res_reg;
    assign digit_out_0  = digit_res_reg[0];
    assign digit_out_1  = digit_res_reg[1];
    assign digit_out_2  = digit_res_reg[2];
    assign digit_out_3  = digit_res_reg[3];
    assign digit_out_4  = digit_res_reg[4];
    assign digit_out_5  = digit_res_reg[5];
    assign digit_out_6  = digit_res_reg[6];
    assign digit_out_7  = digit_res_reg[7];

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mixed-radix index converter.
// Each accepted request is predicted into a queue of awaited results and every
// result is compared field by field with the oldest entry. The radix list is
// reprogrammed between phases while the core is idle: reset values, all
// fifteen, all one, all two, an early zero with live radices behind it, and
// random lists. Requests and result stalls are paced by random waits, with
// some phases running back to back.
// ----------------------------------------------------------------------------
module tb_top
    import mrc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 148;

    typedef logic [NUM_POS-1:0][DIGIT_W-1:0] nibble_vec_t;

    typedef struct packed
    {
        mrc_cmd_t             cmd;
        logic [31:0]          index;
        nibble_vec_t          digit;
    } conv_request_t;

    typedef struct packed
    {
        logic [31:0]          index;
        logic [COUNT_W-1:0]   count;
        nibble_vec_t          digit;
    } conv_result_t;

    class conv_scoreboard;
        logic [DIGIT_W-1:0] radix [NUM_POS];
        conv_result_t       awaited [$];
        int                 errors;
        int                 checked;
        int                 encodes;
        int                 decodes;

        function new();
            errors  = 0;
            checked = 0;
            encodes = 0;
            decodes = 0;
            foreach (radix[i])
            begin
                radix[i] = '0;
            end
        endfunction

        function void note_request(conv_request_t req);
            conv_result_t res;
            logic [31:0]  acc;
            int           n;
            res = '0;
            n   = 0;
            while (n < NUM_POS && radix[n] != 0)
            begin
                n++;
            end
            res.count = COUNT_W'(n);
            if (req.cmd == CMD_ENCODE)
            begin
                acc = '0;
                for (int i = 0; i < n; i++)
                begin
                    acc = acc * radix[i] + req.digit[i];
                end
                res.index = acc;
                encodes++;
            end
            else
            begin
                acc = req.index;
                for (int i = n - 1; i >= 0; i--)
                begin
                    res.digit[i] = DIGIT_W'(acc % radix[i]);
                    acc          = acc / radix[i];
                end
                decodes++;
            end
            awaited.push_back(res);
        endfunction

        function void check_result(conv_result_t got);
            conv_result_t want;
            if (awaited.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.index !== want.index)
            begin
                $error("index_out: expected %0d, got %0d", want.index, got.index);
                errors++;
            end
            if (got.count !== want.count)
            begin
                $error("active_count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            for (int i = 0; i < NUM_POS; i++)
            begin
                if (got.digit[i] !== want.digit[i])
                begin
                    $error("digit_out_%0d: expected %0d, got %0d",
                           i, want.digit[i], got.digit[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [POS_W-1:0]     cfg_index;
    logic [DIGIT_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    mrc_cmd_t             cmd;
    logic [31:0]          index_in;
    logic [DIGIT_W-1:0]   digit_in_0;
    logic [DIGIT_W-1:0]   digit_in_1;
    logic [DIGIT_W-1:0]   digit_in_2;
    logic [DIGIT_W-1:0]   digit_in_3;
    logic [DIGIT_W-1:0]   digit_in_4;
    logic [DIGIT_W-1:0]   digit_in_5;
    logic [DIGIT_W-1:0]   digit_in_6;
    logic [DIGIT_W-1:0]   digit_in_7;
    logic                 out_valid;
    logic                 out_stall;
    logic [31:0]          index_out;
    logic [COUNT_W-1:0]   active_count;
    logic [DIGIT_W-1:0]   digit_out_0;
    logic [DIGIT_W-1:0]   digit_out_1;
    logic [DIGIT_W-1:0]   digit_out_2;
    logic [DIGIT_W-1:0]   digit_out_3;
    logic [DIGIT_W-1:0]   digit_out_4;
    logic [DIGIT_W-1:0]   digit_out_5;
    logic [DIGIT_W-1:0]   digit_out_6;
    logic [DIGIT_W-1:0]   digit_out_7;

    conv_scoreboard sb;
    bit             pace_free;
    int             result_hold;
    int             quiet_cycles;
    int             radix_settings;

    mixed_radix_index_convert_core dut (.*);

    always #2 clk = ~clk;

    function automatic int draw_wait();
        return pace_free ? 0 : int'($urandom_range(0, 4));
    endfunction

    always @(posedge clk)
    begin : result_sink
        conv_result_t got;
        if (rst_n === 1'b1)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got.index = index_out;
                got.count = active_count;
                got.digit = {digit_out_7, digit_out_6, digit_out_5, digit_out_4,
                             digit_out_3, digit_out_2, digit_out_1, digit_out_0};
                sb.check_result(got);
                result_hold = draw_wait();
            end
            else if (out_valid === 1'b1 && result_hold != 0)
            begin
                result_hold--;
            end
            out_stall <= (result_hold != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0) || rst_n !== 1'b1)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $error("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("tb_top: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input conv_request_t req);
        int gap;
        gap = draw_wait();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= req.cmd;
        index_in   <= req.index;
        digit_in_0 <= req.digit[0];
        digit_in_1 <= req.digit[1];
        digit_in_2 <= req.digit[2];
        digit_in_3 <= req.digit[3];
        digit_in_4 <= req.digit[4];
        digit_in_5 <= req.digit[5];
        digit_in_6 <= req.digit[6];
        digit_in_7 <= req.digit[7];
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_request(req);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic program_radices(input nibble_vec_t r);
        for (int i = 0; i < NUM_POS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= POS_W'(i);
            cfg_data  <= r[i];
            sb.radix[i] = r[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        radix_settings++;
    endtask

    task automatic send_op(input mrc_cmd_t c, input logic [31:0] idx, input nibble_vec_t d);
        conv_request_t req;
        req.cmd   = c;
        req.index = idx;
        req.digit = d;
        send_request(req);
    endtask

    function automatic nibble_vec_t random_radices(int style);
        nibble_vec_t r;
        int          stop;
        stop = $urandom_range(0, NUM_POS);
        for (int i = 0; i < NUM_POS; i++)
        begin
            case (style)
                1:       r[i] = DIGIT_W'($urandom_range(2, 3));
                2:       r[i] = 4'hF;
                3:       r[i] = 4'h1;
                default:
                begin
                    if (i == stop)
                        r[i] = '0;
                    else if (i > stop)
                        r[i] = DIGIT_W'($urandom_range(0, 15));
                    else
                        r[i] = DIGIT_W'($urandom_range(1, 15));
                end
            endcase
        end
        return r;
    endfunction

    function automatic conv_request_t random_request(nibble_vec_t r);
        conv_request_t     req;
        longint unsigned   span;
        int                n;
        req.cmd = $urandom_range(0, 1) ? CMD_DECODE : CMD_ENCODE;
        span    = 1;
        n       = 0;
        while (n < NUM_POS && r[n] != 0)
        begin
            span *= r[n];
            n++;
        end
        case ($urandom_range(0, 9))
            0:       req.index = '0;
            1:       req.index = '1;
            2, 3:    req.index = $urandom;
            default: req.index = 32'(longint'($urandom) % span);
        endcase
        for (int i = 0; i < NUM_POS; i++)
        begin
            if (i < n && $urandom_range(0, 3) != 0)
                req.digit[i] = DIGIT_W'($urandom_range(0, r[i] - 1));
            else
                req.digit[i] = DIGIT_W'($urandom_range(0, 15));
        end
        return req;
    endfunction

    initial
    begin
        int          styles [9];
        nibble_vec_t r;
        styles = '{0, 2, 0, 1, 0, 3, 0, 0, 1};
        sb = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        cmd            = CMD_ENCODE;
        index_in       = '0;
        digit_in_0     = '0;
        digit_in_1     = '0;
        digit_in_2     = '0;
        digit_in_3     = '0;
        digit_in_4     = '0;
        digit_in_5     = '0;
        digit_in_6     = '0;
        digit_in_7     = '0;
        out_stall      = 1'b0;
        result_hold    = 0;
        quiet_cycles   = 0;
        pace_free      = 1'b0;
        radix_settings = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // radices still at reset: empty list
        send_op(CMD_ENCODE, 32'h0, 32'hFFFFFFFF);
        send_op(CMD_DECODE, 32'hFFFFFFFF, 32'h0);
        settle();

        program_radices(32'hFFFFFFFF);
        send_op(CMD_ENCODE, 32'h0, 32'hFFFFFFFF);
        send_op(CMD_ENCODE, 32'h0, 32'hEEEEEEEE);
        send_op(CMD_ENCODE, 32'hFFFFFFFF, 32'h0);
        send_op(CMD_DECODE, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_op(CMD_DECODE, 32'h0, 32'hFFFFFFFF);
        send_op(CMD_DECODE, 32'd2562890624, 32'h0);
        settle();

        program_radices(32'h11111111);
        send_op(CMD_DECODE, 32'hFFFFFFFF, 32'h0);
        send_op(CMD_ENCODE, 32'h0, 32'hFFFFFFFF);
        settle();

        // zero at position two, live radices behind it
        program_radices(32'hFFFF7032);
        send_op(CMD_ENCODE, 32'h0, 32'hFFFFFF21);
        send_op(CMD_DECODE, 32'd5, 32'h0);
        send_op(CMD_DECODE, 32'hFFFFFFFF, 32'h0);
        send_op(CMD_ENCODE, 32'h0, 32'hFFFFFFFF);
        settle();

        program_radices(32'hFFFFFFF0);
        send_op(CMD_ENCODE, 32'h0, 32'hFFFFFFFF);
        send_op(CMD_DECODE, 32'hA5A5A5A5, 32'h0);
        settle();

        program_radices(32'h22222222);
        send_op(CMD_DECODE, 32'hFFFFFFFF, 32'h0);
        send_op(CMD_DECODE, 32'h000000A5, 32'h0);
        send_op(CMD_ENCODE, 32'h0, 32'h01010101);
        send_op(CMD_ENCODE, 32'h0, 32'hFFFFFFFF);
        settle();

        foreach (styles[p])
        begin
            pace_free = (p % 3 == 2);
            r = random_radices(styles[p]);
            program_radices(r);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_request(random_request(r));
            end
            settle();
        end
        pace_free = 1'b0;

        repeat (16) @(posedge clk);
        $display("summary: %0d results checked (%0d encode, %0d decode) over %0d radix lists",
                 sb.checked, sb.encodes, sb.decodes, radix_settings);
        if (sb.errors == 0 && sb.awaited.size() == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/mrc_pkg.sv
design/mrc_step_unit.sv
design/mixed_radix_index_convert_core.sv
bench/tb_top.sv
